FILE: hw/rtl/assert_macros.svh
// assertion macros used by the rtl back end (tfidf_back)
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold whenever reset is released
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication checked at every rising clock edge
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/tfidf_pkg.sv
// shared types and constants of the tf-idf top-k ranker
package tfidf_pkg;
  localparam int unsigned TopK = 10;
  localparam int unsigned IdxW = $clog2(TopK);
  localparam int unsigned FillW = $clog2(TopK + 1);
  localparam int unsigned QueueDepth = 2;
  localparam logic [31:0] Log10Of2Q32 = 32'd1292913986;
  localparam logic [0:0] RegCorpusSize = 1'b0;

  typedef struct packed {
    logic [15:0] doc_id;
    logic [15:0] term_count;
    logic [23:0] doc_words;
    logic        last_hit;
  } hit_t;

  typedef struct packed {
    logic [15:0] ranked_doc;
    logic [18:0] score;
    logic        last_result;
  } result_t;
endpackage

FILE: hw/rtl/tfidf_front.sv
// front end: accepts hits, fixes zero word counts, and queues them
module tfidf_front import tfidf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  hit_t in_hit_i,
  output logic q_valid_o,
  input  logic q_ready_i,
  output hit_t q_hit_o
);
  localparam int unsigned PtrW = $clog2(QueueDepth);
  hit_t mem_q [QueueDepth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [PtrW:0] cnt_q, cnt_d;
  logic push, pop;
  hit_t fixed;

  always_comb begin
    fixed = in_hit_i;
    if (in_hit_i.doc_words == '0) begin
      fixed.doc_words = 24'd1;
    end
  end

  assign in_ready_o = (cnt_q != (PtrW+1)'(QueueDepth));
  assign q_valid_o = (cnt_q != '0);
  assign push = in_valid_i && in_ready_o;
  assign pop = q_valid_o && q_ready_i;
  assign q_hit_o = mem_q[rd_q];
  assign wr_d = push ? wr_q + 1'b1 : wr_q;
  assign rd_d = pop ? rd_q + 1'b1 : rd_q;
  assign cnt_d = cnt_q + (PtrW+1)'(push) - (PtrW+1)'(pop);

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= fixed;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      wr_q <= wr_d;
      rd_q <= rd_d;
      cnt_q <= cnt_d;
    end
  end
endmodule

FILE: hw/rtl/tfidf_idf.sv
// iterative idf unit: log10(p/q) by repeated squaring
module tfidf_idf import tfidf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [16:0] p_i,
  input  logic [16:0] q_i,
  output logic        done_o,
  output logic [18:0] idf_o
);
  typedef enum logic [2:0] {
    StIdle, StExp, StDiv, StSq, StMul, StDone
  } state_e;
  state_e st_q;
  logic [4:0]  e_q;
  logic [16:0] p_q;
  logic [37:0] qs_q;
  logic [47:0] rem_q;
  logic [32:0] y_q;
  logic [31:0] frac_q;
  logic [5:0]  i_q;
  logic [18:0] idf_q;
  logic [65:0] sq;
  logic [32:0] sq_t;
  logic [63:0] mlo;
  logic [36:0] mhi;
  logic [63:0] tsum;
  logic [48:0] trial;

  assign sq = y_q * y_q;
  assign sq_t = sq[63:31];
  assign mlo = frac_q * Log10Of2Q32;
  assign mhi = e_q * Log10Of2Q32;
  assign tsum = {32'd0, mlo[63:32]} + {27'd0, mhi} + 64'd32768;
  assign trial = {rem_q, 1'b0};
  assign done_o = (st_q == StDone);
  assign idf_o = idf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      e_q <= '0; p_q <= '0; qs_q <= '0; rem_q <= '0;
      y_q <= '0; frac_q <= '0; i_q <= '0; idf_q <= '0;
    end else begin
      unique case (st_q)
        StIdle: begin
          if (start_i) begin
            p_q <= p_i;
            qs_q <= {21'd0, q_i};
            e_q <= '0;
            st_q <= StExp;
          end
        end
        StExp: begin
          if (e_q < 5'd20 && {qs_q[36:0], 1'b0} <= {21'd0, p_q}) begin
            qs_q <= {qs_q[36:0], 1'b0};
            e_q <= e_q + 5'd1;
          end else begin
            rem_q <= '0;
            y_q <= '0;
            i_q <= '0;
            st_q <= StDiv;
          end
        end
        StDiv: begin
          // restoring division of p*2^31 by q*2^e, one bit a cycle
          if ({rem_q[46:0], (i_q < 6'd17) ? p_q[5'd16 - i_q[4:0]] : 1'b0}
              >= {10'd0, qs_q}) begin
            rem_q <= {rem_q[46:0], (i_q < 6'd17) ? p_q[5'd16 - i_q[4:0]] : 1'b0}
                     - {10'd0, qs_q};
            y_q <= {y_q[31:0], 1'b1};
          end else begin
            rem_q <= {rem_q[46:0], (i_q < 6'd17) ? p_q[5'd16 - i_q[4:0]] : 1'b0};
            y_q <= {y_q[31:0], 1'b0};
          end
          if (i_q == 6'd47) begin
            i_q <= '0;
            frac_q <= '0;
            st_q <= StSq;
          end else begin
            i_q <= i_q + 6'd1;
          end
        end
        StSq: begin
          if (sq_t[32]) begin
            y_q <= {1'b0, sq_t[32:1]};
            frac_q <= {frac_q[30:0], 1'b1};
          end else begin
            y_q <= sq_t;
            frac_q <= {frac_q[30:0], 1'b0};
          end
          if (i_q == 6'd31) begin
            st_q <= StMul;
          end else begin
            i_q <= i_q + 6'd1;
          end
        end
        StMul: begin
          idf_q <= tsum[34:16];
          st_q <= StDone;
        end
        StDone: st_q <= StIdle;
        default: st_q <= StIdle;
      endcase
    end
  end

  logic unused_trial;
  assign unused_trial = ^trial;
endmodule

FILE: hw/rtl/tfidf_back.sv
// back end: sorted insertion of hits and ranked emission of scores
module tfidf_back import tfidf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [15:0] corpus_size_i,
  input  logic        q_valid_i,
  output logic        q_ready_o,
  input  hit_t        q_hit_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output result_t     out_res_o,
  output logic        busy_o
);
  `include "assert_macros.svh"
  typedef enum logic [2:0] {
    StLoad, StIdfGo, StIdfWait, StTf, StScore, StOut
  } state_e;
  state_e st_q;
  logic [15:0] id_q [TopK];
  logic [15:0] cnt_q [TopK];
  logic [23:0] wrd_q [TopK];
  logic [FillW-1:0] fill_q;
  logic [15:0] hits_q;
  logic [IdxW-1:0] k_q;
  logic [18:0] idf_q;
  logic [40:0] rem_q;
  logic [16:0] tf_q;
  logic [5:0]  bit_q;
  logic [35:0] prod_q;
  logic        ov_q;
  result_t     res_q;
  logic        res_v_q;
  logic [TopK-1:0] ge;
  logic [IdxW-1:0] pos;
  logic [FillW-1:0] pos_w;
  logic        take;
  logic        idf_done;
  logic [18:0] idf_val;
  logic [16:0] qv;
  logic [16:0] pv;

  for (genvar g = 0; g < TopK; g++) begin : g_cmp
    assign ge[g] = (FillW'(g) < fill_q) &&
        ({24'd0, cnt_q[g]} * {16'd0, q_hit_i.doc_words}
         >= {24'd0, q_hit_i.term_count} * {16'd0, wrd_q[g]});
  end

  always_comb begin
    pos_w = FillW'(TopK);
    for (int j = TopK - 1; j >= 0; j--) begin
      if (!ge[j]) pos_w = FillW'(j);
    end
    pos = pos_w[IdxW-1:0];
  end

  assign qv = {1'b0, hits_q} + 17'd1;
  assign pv = qv + {1'b0, corpus_size_i};
  assign q_ready_o = (st_q == StLoad);
  assign take = q_valid_i && q_ready_o;
  assign out_valid_o = res_v_q;
  assign out_res_o = res_q;
  assign busy_o = (st_q != StLoad) || res_v_q;

  tfidf_idf u_idf (
    .clk_i, .rst_ni,
    .start_i(st_q == StIdfGo && corpus_size_i != '0),
    .p_i(pv), .q_i(qv),
    .done_o(idf_done), .idf_o(idf_val)
  );

  always_ff @(posedge clk_i) begin
    if (take && pos_w != FillW'(TopK)) begin
      for (int j = TopK - 1; j > 0; j--) begin
        if (IdxW'(j) > pos) begin
          id_q[j] <= id_q[j-1];
          cnt_q[j] <= cnt_q[j-1];
          wrd_q[j] <= wrd_q[j-1];
        end
      end
      id_q[pos] <= q_hit_i.doc_id;
      cnt_q[pos] <= q_hit_i.term_count;
      wrd_q[pos] <= q_hit_i.doc_words;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StLoad;
      fill_q <= '0; hits_q <= '0; k_q <= '0; idf_q <= '0;
      rem_q <= '0; tf_q <= '0; bit_q <= '0; prod_q <= '0; ov_q <= 1'b0;
      res_q <= '0; res_v_q <= 1'b0;
    end else begin
      if (res_v_q && out_ready_i && st_q != StOut) res_v_q <= 1'b0;
      unique case (st_q)
        StLoad: begin
          if (take) begin
            if (pos_w != FillW'(TopK) && fill_q != FillW'(TopK)) begin
              fill_q <= fill_q + 1'b1;
            end
            if (hits_q != 16'hFFFF) hits_q <= hits_q + 16'd1;
            if (q_hit_i.last_hit) begin
              st_q <= StIdfGo;
            end
          end
        end
        StIdfGo: begin
          if (corpus_size_i == '0) begin
            fill_q <= '0; hits_q <= '0; st_q <= StLoad;
          end else begin
            st_q <= StIdfWait;
          end
        end
        StIdfWait: begin
          if (idf_done) begin
            idf_q <= idf_val;
            k_q <= '0;
            rem_q <= '0; tf_q <= '0; bit_q <= '0;
            st_q <= StTf;
          end
        end
        StTf: begin
          // tf = floor(count*2^16/words), one quotient bit a cycle
          if ({rem_q[39:0], (bit_q < 6'd16) ? cnt_q[k_q][4'd15 - bit_q[3:0]] : 1'b0}
              >= {17'd0, wrd_q[k_q]}) begin
            rem_q <= {rem_q[39:0], (bit_q < 6'd16) ? cnt_q[k_q][4'd15 - bit_q[3:0]] : 1'b0}
                     - {17'd0, wrd_q[k_q]};
            ov_q <= ov_q | tf_q[16];
            tf_q <= {tf_q[15:0], 1'b1};
          end else begin
            rem_q <= {rem_q[39:0], (bit_q < 6'd16) ? cnt_q[k_q][4'd15 - bit_q[3:0]] : 1'b0};
            ov_q <= ov_q | tf_q[16];
            tf_q <= {tf_q[15:0], 1'b0};
          end
          if (bit_q == 6'd31) st_q <= StScore;
          else bit_q <= bit_q + 6'd1;
        end
        StScore: begin
          prod_q <= ((ov_q || tf_q > 17'd65536) ? 17'd65536 : tf_q) * idf_q;
          st_q <= StOut;
        end
        StOut: begin
          if (!res_v_q || out_ready_i) begin
            res_q.ranked_doc <= id_q[k_q];
            res_q.score <= prod_q[34:16];
            res_q.last_result <= (FillW'(k_q) + 1'b1 == fill_q);
            res_v_q <= 1'b1;
            rem_q <= '0; tf_q <= '0; bit_q <= '0; ov_q <= 1'b0;
            if (FillW'(k_q) + 1'b1 == fill_q) begin
              fill_q <= '0; hits_q <= '0; st_q <= StLoad;
            end else begin
              k_q <= k_q + 1'b1;
              st_q <= StTf;
            end
          end else if (res_v_q && out_ready_i) begin
            res_v_q <= 1'b0;
          end
        end
        default: st_q <= StLoad;
      endcase
    end
  end

  `ASSERT_ALWAYS(a_fill_bound, fill_q <= FillW'(TopK), "kept fill above capacity")
  `ASSERT_IMPLY(a_no_take_busy, st_q != StLoad, !take, "hit taken while ranking")
  `ASSERT_IMPLY(a_emit_nonempty, st_q == StOut, fill_q != '0, "emit with empty store")
endmodule

FILE: hw/rtl/tfidf_top_k_ranker.sv
// top level of the tf-idf top-k ranker
// Hits stream in at up to one per cycle and are inserted into a sorted top-10
// store in the cycle they are taken; a two-entry queue decouples input from the
// ranking engine. After the last hit the engine computes the idf (an exponent
// search of up to 17 steps, a bit-serial 48-step divider and 32 squaring
// steps), or drops the query when the corpus size is 0, then runs the tf divide
// and score multiply for each result, waiting while the output is stalled;
// meanwhile the engine takes no hit and the queue holds at most two.
module tfidf_top_k_ranker import tfidf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [55:0] s_axis_tdata_i,   // doc_id, term_count, doc_words
  input  logic        s_axis_tlast_i,   // last_hit
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // ranked_doc, score, zero pad
  output logic        m_axis_tlast_o,   // last_result
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [15:0] corpus_q;
  hit_t in_hit, q_hit;
  result_t res;
  logic q_valid, q_ready, busy;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegCorpusSize) ? {16'd0, corpus_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      corpus_q <= '0;
    end else if (psel && penable && pwrite && paddr[2] == RegCorpusSize) begin
      corpus_q <= pwdata[15:0];
    end
  end

  assign in_hit = '{doc_id: s_axis_tdata_i[15:0], term_count: s_axis_tdata_i[31:16],
                    doc_words: s_axis_tdata_i[55:32], last_hit: s_axis_tlast_i};

  tfidf_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid_i), .in_ready_o(s_axis_tready_o), .in_hit_i(in_hit),
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_hit_o(q_hit)
  );

  tfidf_back u_back (
    .clk_i, .rst_ni,
    .corpus_size_i(corpus_q),
    .q_valid_i(q_valid), .q_ready_o(q_ready), .q_hit_i(q_hit),
    .out_valid_o(m_axis_tvalid_o), .out_ready_i(m_axis_tready_i),
    .out_res_o(res), .busy_o(busy)
  );

  assign m_axis_tdata_o = {5'd0, res.score, res.ranked_doc};
  assign m_axis_tlast_o = res.last_result;

  logic unused_busy;
  assign unused_busy = busy ^ paddr[0] ^ paddr[1];
endmodule

FILE: sim/tfidf_checker.sv
// checker of the tf-idf top-k ranker: watches the streams, predicts and compares results
module tfidf_checker import tfidf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [55:0] s_axis_tdata_i,   // doc_id, term_count, doc_words
  input  logic        s_axis_tlast_i,   // last_hit
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [39:0] m_axis_tdata_i,   // ranked_doc, score, zero pad
  input  logic        m_axis_tlast_i,   // last_result
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count_o,
  output int          pending_o
);

  logic [15:0] top_ids   [TopK];
  logic [15:0] top_counts[TopK];
  logic [23:0] top_words [TopK];
  int unsigned top_fill;
  logic [15:0] hit_count;
  logic [15:0] corpus;
  result_t     ranked_q[$];
  int          fails = 0;

  assign fail_count_o = fails;
  assign pending_o    = ranked_q.size();

  task automatic report(string what, logic [31:0] want, logic [31:0] got);
    $display("mismatch: %s expected %0d got %0d", what, want, got);
    fails++;
  endtask

  // log10 of p/q in q3.16, via log2 by repeated squaring
  function automatic logic [63:0] idf_q16(logic [63:0] p, logic [63:0] q);
    int unsigned e;
    logic [63:0] y, frac, lo, t;
    e = 0;
    while (e < 20 && (q << (e + 1)) <= p) e++;
    y = (p << 31) / (q << e);
    frac = 0;
    for (int i = 0; i < 32; i++) begin
      y = (y * y) >> 31;
      frac = frac << 1;
      if (y >= 64'h1_0000_0000) begin
        y = y >> 1;
        frac = frac | 64'd1;
      end
    end
    lo = (frac * 64'(Log10Of2Q32)) >> 32;
    t  = lo + 64'(e) * 64'(Log10Of2Q32);
    return (t + 64'h8000) >> 16;
  endfunction

  task automatic take_hit(logic [15:0] id, logic [15:0] cnt, logic [23:0] wrd, logic last);
    int unsigned pos, hi;
    logic [63:0] q, idf, tf;
    result_t r;
    if (wrd == 0) wrd = 24'd1;
    pos = 0;
    while (pos < top_fill &&
           64'(top_counts[pos]) * 64'(wrd) >= 64'(cnt) * 64'(top_words[pos])) pos++;
    if (pos < TopK) begin
      hi = (top_fill < TopK) ? top_fill : TopK - 1;
      for (int i = hi; i > pos; i--) begin
        top_ids[i]    = top_ids[i-1];
        top_counts[i] = top_counts[i-1];
        top_words[i]  = top_words[i-1];
      end
      top_ids[pos] = id;
      top_counts[pos] = cnt;
      top_words[pos] = wrd;
      if (top_fill < TopK) top_fill++;
    end
    if (hit_count != 16'hFFFF) hit_count++;
    if (last) begin
      if (corpus != 0 && hit_count != 0) begin
        q = 64'(hit_count) + 1;
        idf = idf_q16(q + 64'(corpus), q);
        for (int k = 0; k < top_fill; k++) begin
          tf = (64'(top_counts[k]) << 16) / 64'(top_words[k]);
          if (tf > 64'd65536) tf = 64'd65536;
          r.ranked_doc  = top_ids[k];
          r.score       = 19'((tf * idf) >> 16);
          r.last_result = (k + 1 == top_fill);
          ranked_q.insert(ranked_q.size(), r);
        end
      end
      top_fill = 0;
      hit_count = 0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      top_fill  = 0;
      hit_count = 0;
      corpus    = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == 3'(4 * RegCorpusSize))
        corpus = pwdata[15:0];
      if (s_axis_tvalid_i && s_axis_tready_i)
        take_hit(s_axis_tdata_i[15:0], s_axis_tdata_i[31:16], s_axis_tdata_i[55:32],
                 s_axis_tlast_i);
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (ranked_q.size() == 0) begin
          report("unexpected result, doc", 32'd0, 32'(m_axis_tdata_i[15:0]));
        end else begin
          want = ranked_q.pop_front();
          if (m_axis_tdata_i[15:0] != want.ranked_doc)
            report("ranked_doc", 32'(want.ranked_doc), 32'(m_axis_tdata_i[15:0]));
          if (m_axis_tdata_i[34:16] != want.score)
            report("score", 32'(want.score), 32'(m_axis_tdata_i[34:16]));
          if (m_axis_tlast_i != want.last_result)
            report("last_result", 32'(want.last_result), 32'(m_axis_tlast_i));
        end
      end
    end
  end

endmodule

FILE: sim/testbench.sv
// testbench top of the tf-idf top-k ranker: stimulus, stalls and verdict
module testbench;
  import tfidf_pkg::*;

  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned DrainCycles = 600;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [55:0] s_data = '0;     // doc_id, term_count, doc_words
  logic        s_last = 1'b0;   // last_hit
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [39:0] m_data;          // ranked_doc, score, zero pad
  logic        m_last;          // last_result
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count;
  int          pending;
  int unsigned cycles = 0;
  int unsigned hits_sent = 0;
  int unsigned burst_left = 0;
  bit          no_gaps = 0;
  int unsigned stall_mode = 0;
  int unsigned stall_left = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  tfidf_top_k_ranker dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i(s_valid), .s_axis_tready_o(s_ready),
    .s_axis_tdata_i(s_data), .s_axis_tlast_i(s_last),
    .m_axis_tvalid_o(m_valid), .m_axis_tready_i(m_ready),
    .m_axis_tdata_o(m_data), .m_axis_tlast_o(m_last),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  tfidf_checker u_checker (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i(s_valid), .s_axis_tready_i(s_ready),
    .s_axis_tdata_i(s_data), .s_axis_tlast_i(s_last),
    .m_axis_tvalid_i(m_valid), .m_axis_tready_i(m_ready),
    .m_axis_tdata_i(m_data), .m_axis_tlast_i(m_last),
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // receiver stall pattern, mode changes every stretch
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(8, 80);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0, 1: m_ready <= 1'b1;
      2: m_ready <= ($urandom_range(0, 1) == 1);
      default: m_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  task automatic send_hit(logic [15:0] id, logic [15:0] cnt, logic [23:0] wrd, logic last);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = no_gaps ? 0 : $urandom_range(0, 6);
      burst_left = $urandom_range(1, 12);
      if (gap > 0) begin
        s_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_valid <= 1'b1;
    s_data  <= {wrd, cnt, id};
    s_last  <= last;
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
    hits_sent++;
  endtask

  task automatic drain;
    s_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_corpus(logic [15:0] n);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(4 * RegCorpusSize);
    pwdata  <= {16'($urandom_range(0, 65535)), n};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic random_query(int unsigned len);
    logic [15:0] cnt;
    logic [23:0] wrd;
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(0, 5))
        0: begin  // small values for ties and saturated tf
          cnt = 16'($urandom_range(0, 4));
          wrd = 24'($urandom_range(0, 4));
        end
        1: begin
          cnt = 16'($urandom_range(0, 65535));
          wrd = 24'($urandom_range(0, 16777215));
        end
        2: begin
          cnt = 16'hFFFF;
          wrd = $urandom_range(0, 1) ? 24'hFFFFFF : 24'd0;
        end
        default: begin
          cnt = 16'($urandom_range(1, 300));
          wrd = 24'($urandom_range(1, 5000));
        end
      endcase
      send_hit(16'($urandom_range(0, 65535)), cnt, wrd, i == len - 1);
    end
  endtask

  initial begin
    logic [15:0] corpus_pick;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part
    set_corpus(16'd1);
    send_hit(16'd0, 16'd0, 24'd0, 1'b1);
    send_hit(16'hFFFF, 16'hFFFF, 24'd0, 1'b0);
    send_hit(16'd7, 16'd1, 24'hFFFFFF, 1'b1);
    for (int i = 0; i < 12; i++)
      send_hit(16'(100 + i), 16'((i % 3) + 1), 24'(2 * ((i % 3) + 1)), i == 11);
    drain();
    set_corpus(16'd0);
    send_hit(16'd3, 16'd5, 24'd10, 1'b0);
    send_hit(16'd4, 16'd6, 24'd10, 1'b1);
    drain();
    set_corpus(16'hFFFF);
    send_hit(16'h5555, 16'hAAAA, 24'h555555, 1'b0);
    send_hit(16'hAAAA, 16'h5555, 24'hAAAAAA, 1'b1);
    drain();

    // random part, one corpus setting per phase
    while (hits_sent < 220) begin
      case ($urandom_range(0, 4))
        0: corpus_pick = 16'd0;
        1: corpus_pick = 16'hFFFF;
        2: corpus_pick = 16'd1;
        default: corpus_pick = 16'($urandom_range(0, 65535));
      endcase
      set_corpus(corpus_pick);
      no_gaps = ($urandom_range(0, 3) == 0);
      for (int j = 0; j < 3; j++)
        random_query($urandom_range(0, 4) == 0 ? $urandom_range(11, 24)
                                               : $urandom_range(1, 10));
      drain();
    end

    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
